// ----- design/mip_level_size_calc_core_defines.svh -----
// Assertion macros for the checker file of the mip level size calculator.
// Depends on clk and rst being visible in the scope that expands them.
`ifndef MIP_LEVEL_SIZE_CALC_CORE_DEFINES_SVH
`define MIP_LEVEL_SIZE_CALC_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MLSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MLSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mlsc_pkg.sv -----
// Shared types, widths and helpers of the mip level size calculator.
// Used by every module of the block; depends on nothing.
package mlsc_pkg;

  localparam int MAX_LEVELS = 15;

  localparam int LEVEL_W   = 4;
  localparam int WIDTH_W   = 15;
  localparam int DEPTH_W   = 12;
  localparam int PBITS_W   = 8;
  localparam int BBYTES_W  = 5;
  localparam int LCOUNT_W  = 4;
  localparam int SIZE_W    = 44;
  localparam int PITCH_W   = 19;
  localparam int TOTAL_W   = 47;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;

  localparam int BMULT_W = 6;
  localparam int AREA_W  = 2 * WIDTH_W;
  localparam int VOL_W   = 17;
  localparam int PROD_W  = 47;
  localparam int PMUL_W  = WIDTH_W + PBITS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_WIDTH    = 3'd0,
    REG_BASE_HEIGHT   = 3'd1,
    REG_BASE_DEPTH    = 3'd2,
    REG_PIXEL_BITS    = 3'd3,
    REG_IS_COMPRESSED = 3'd4,
    REG_BLOCK_BYTES   = 3'd5,
    REG_LEVEL_COUNT   = 3'd6,
    REG_IS_CUBE       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  base_width;
    logic [WIDTH_W-1:0]  base_height;
    logic [DEPTH_W-1:0]  base_depth;
    logic [PBITS_W-1:0]  pixel_bits;
    logic                is_compressed;
    logic [BBYTES_W-1:0] block_bytes;
    logic [LCOUNT_W-1:0] level_count;
    logic                is_cube;
  } cfg_t;

  typedef struct packed {
    logic               issue;
    logic [LEVEL_W-1:0] idx;
    logic               scale;
    logic               load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } ctrl_sts_t;

  // Bytes per storage unit: per 4x4 block, or ceil(pixel_bits / 8) per pixel.
  function automatic logic [BMULT_W-1:0] unit_bytes(input cfg_t c);
    logic [PBITS_W:0] padded;
    padded = {1'b0, c.pixel_bits} + (PBITS_W+1)'(7);
    if (c.is_compressed) begin
      unit_bytes = BMULT_W'(c.block_bytes);
    end else begin
      unit_bytes = BMULT_W'(padded >> 3);
    end
  endfunction

endpackage

// ----- design/mlsc_cfg_regs.sv -----
// Configuration register file of the mip level size calculator.
// Depends on mlsc_pkg for the register indexes and the cfg_t layout.
module mlsc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr,
  input  logic [mlsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mlsc_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_width    <= mlsc_pkg::WIDTH_W'(1);
      cfg.base_height   <= mlsc_pkg::WIDTH_W'(1);
      cfg.base_depth    <= mlsc_pkg::DEPTH_W'(1);
      cfg.pixel_bits    <= mlsc_pkg::PBITS_W'(32);
      cfg.is_compressed <= 1'b0;
      cfg.block_bytes   <= mlsc_pkg::BBYTES_W'(8);
      cfg.level_count   <= mlsc_pkg::LCOUNT_W'(1);
      cfg.is_cube       <= 1'b0;
    end else if (cfg_wr) begin
      case (mlsc_pkg::reg_idx_t'(cfg_index))
        mlsc_pkg::REG_BASE_WIDTH:    cfg.base_width    <= cfg_data[mlsc_pkg::WIDTH_W-1:0];
        mlsc_pkg::REG_BASE_HEIGHT:   cfg.base_height   <= cfg_data[mlsc_pkg::WIDTH_W-1:0];
        mlsc_pkg::REG_BASE_DEPTH:    cfg.base_depth    <= cfg_data[mlsc_pkg::DEPTH_W-1:0];
        mlsc_pkg::REG_PIXEL_BITS:    cfg.pixel_bits    <= cfg_data[mlsc_pkg::PBITS_W-1:0];
        mlsc_pkg::REG_IS_COMPRESSED: cfg.is_compressed <= cfg_data[0];
        mlsc_pkg::REG_BLOCK_BYTES:   cfg.block_bytes   <= cfg_data[mlsc_pkg::BBYTES_W-1:0];
        mlsc_pkg::REG_LEVEL_COUNT:   cfg.level_count   <= cfg_data[mlsc_pkg::LCOUNT_W-1:0];
        mlsc_pkg::REG_IS_CUBE:       cfg.is_cube       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/mlsc_ctrl.sv -----
// Sequencer of the mip level size calculator: issues every level into the datapath.
// Depends on mlsc_pkg for the command and status structs.
module mlsc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  busy,
  output mlsc_pkg::ctrl_cmd_t   cmd,
  input  mlsc_pkg::ctrl_sts_t   sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_SCALE,
    S_FIN
  } state_t;

  localparam logic [mlsc_pkg::LEVEL_W-1:0] LAST_LEVEL = '1;

  state_t                       state;
  logic [mlsc_pkg::LEVEL_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      cnt   <= '0;
      cmd   <= '0;
    end else begin
      cmd.issue <= (state == S_RUN);
      cmd.scale <= (state == S_DRAIN) && !cmd.issue && !sts.pipe_busy;
      cmd.load  <= (state == S_FIN) && sts.out_free;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
            busy  <= 1'b1;
            cnt   <= '0;
          end
        end
        S_RUN: begin
          cmd.idx <= cnt;
          cnt     <= cnt + 1'b1;
          if (cnt == LAST_LEVEL) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!cmd.issue && !sts.pipe_busy) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (sts.out_free) begin
            busy  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- design/mlsc_dp.sv -----
// Datapath of the mip level size calculator: dimension, multiply and sum pipeline
// plus the output register. Depends on mlsc_pkg; driven by mlsc_ctrl.
module mlsc_dp #(
  parameter int MAX_LEVELS = mlsc_pkg::MAX_LEVELS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mlsc_pkg::cfg_t                    cfg,
  input  logic                              take,
  input  logic [mlsc_pkg::LEVEL_W-1:0]      level,
  input  mlsc_pkg::ctrl_cmd_t               cmd,
  output mlsc_pkg::ctrl_sts_t               sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mlsc_pkg::WIDTH_W-1:0]      level_width,
  output logic [mlsc_pkg::WIDTH_W-1:0]      level_height,
  output logic [mlsc_pkg::DEPTH_W-1:0]      level_depth,
  output logic [mlsc_pkg::SIZE_W-1:0]       level_size,
  output logic [mlsc_pkg::PITCH_W-1:0]      row_pitch,
  output logic [mlsc_pkg::TOTAL_W-1:0]      total_size
);

  localparam int ACC_W   = mlsc_pkg::PROD_W + $clog2(MAX_LEVELS);
  localparam int SCALE_W = ACC_W + 3;
  localparam int N_W     = mlsc_pkg::LEVEL_W + 1;
  localparam logic [N_W-1:0] MAX_N = N_W'(MAX_LEVELS);

  localparam int W_W = mlsc_pkg::WIDTH_W;
  localparam int D_W = mlsc_pkg::DEPTH_W;

  // Query latch
  logic [mlsc_pkg::LEVEL_W-1:0] lvl_q;

  // Stage A: dimensions of the issued level
  logic [W_W-1:0]  bw, bh, sw, sh, pw, ph, cw, ch, dim_w, dim_h;
  logic [D_W-1:0]  bd, sd, dim_d;
  logic [W_W:0]    wsum, hsum;

  logic                         va;
  logic [mlsc_pkg::LEVEL_W-1:0] tag_a;
  logic [W_W-1:0]               w_a, h_a;
  logic [D_W-1:0]               d_a;

  // Stage B: area, volume factor and pitch
  logic [mlsc_pkg::BMULT_W-1:0] ubytes;
  logic [mlsc_pkg::PBITS_W-1:0] pmul;
  logic [mlsc_pkg::PMUL_W-1:0]  pprod, pitch_raw;

  logic                         vb;
  logic [mlsc_pkg::LEVEL_W-1:0] tag_b;
  logic [mlsc_pkg::AREA_W-1:0]  area_b;
  logic [mlsc_pkg::VOL_W-1:0]   vol_b;

  // Stage C: level byte size
  logic                         vc;
  logic [mlsc_pkg::LEVEL_W-1:0] tag_c;
  logic [mlsc_pkg::PROD_W-1:0]  prod_c;

  // Sum and captured results
  logic [N_W-1:0]               n0, n_lim;
  logic [ACC_W-1:0]             acc;
  logic [SCALE_W-1:0]           scaled;
  logic [W_W-1:0]               res_w, res_h;
  logic [D_W-1:0]               res_d;
  logic [mlsc_pkg::PITCH_W-1:0] res_pitch;
  logic [mlsc_pkg::SIZE_W-1:0]  res_size;
  logic [mlsc_pkg::TOTAL_W-1:0] res_total;

  always_comb begin
    bw = (cfg.base_width  == '0) ? W_W'(1) : cfg.base_width;
    bh = (cfg.base_height == '0) ? W_W'(1) : cfg.base_height;
    bd = (cfg.base_depth  == '0) ? D_W'(1) : cfg.base_depth;
    sw = bw >> cmd.idx;
    sh = bh >> cmd.idx;
    sd = bd >> cmd.idx;
    pw = (sw == '0) ? W_W'(1) : sw;
    ph = (sh == '0) ? W_W'(1) : sh;
    dim_d = (sd == '0) ? D_W'(1) : sd;
    wsum = {1'b0, pw} + (W_W+1)'(3);
    hsum = {1'b0, ph} + (W_W+1)'(3);
    cw = W_W'(wsum >> 2);
    ch = W_W'(hsum >> 2);
    dim_w = cfg.is_compressed ? cw : pw;
    dim_h = cfg.is_compressed ? ch : ph;
  end

  always_comb begin
    ubytes    = mlsc_pkg::unit_bytes(cfg);
    pmul      = cfg.is_compressed ? mlsc_pkg::PBITS_W'(cfg.block_bytes) : cfg.pixel_bits;
    pprod     = mlsc_pkg::PMUL_W'(w_a) * mlsc_pkg::PMUL_W'(pmul);
    pitch_raw = cfg.is_compressed ? pprod : (pprod >> 3);
  end

  always_comb begin
    n0     = (cfg.level_count == '0) ? N_W'(1) : N_W'(cfg.level_count);
    n_lim  = (n0 > MAX_N) ? MAX_N : n0;
    scaled = cfg.is_cube ? ((SCALE_W'(acc) << 2) + (SCALE_W'(acc) << 1)) : SCALE_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= cmd.issue;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lvl_q <= level;
    end

    tag_a <= cmd.idx;
    w_a   <= dim_w;
    h_a   <= dim_h;
    d_a   <= dim_d;

    tag_b  <= tag_a;
    area_b <= mlsc_pkg::AREA_W'(w_a) * mlsc_pkg::AREA_W'(h_a);
    vol_b  <= mlsc_pkg::VOL_W'(ubytes) * mlsc_pkg::VOL_W'(d_a);
    if (va && tag_a == lvl_q) begin
      res_w     <= w_a;
      res_h     <= h_a;
      res_d     <= d_a;
      res_pitch <= (|pitch_raw[mlsc_pkg::PMUL_W-1:mlsc_pkg::PITCH_W]) ?
                   '1 : pitch_raw[mlsc_pkg::PITCH_W-1:0];
    end

    tag_c  <= tag_b;
    prod_c <= mlsc_pkg::PROD_W'(area_b) * mlsc_pkg::PROD_W'(vol_b);

    if (take) begin
      acc <= '0;
    end else if (vc && (N_W'(tag_c) < n_lim)) begin
      acc <= acc + ACC_W'(prod_c);
    end
    if (vc && tag_c == lvl_q) begin
      res_size <= (|prod_c[mlsc_pkg::PROD_W-1:mlsc_pkg::SIZE_W]) ?
                  '1 : prod_c[mlsc_pkg::SIZE_W-1:0];
    end

    if (cmd.scale) begin
      res_total <= (|scaled[SCALE_W-1:mlsc_pkg::TOTAL_W]) ?
                   '1 : scaled[mlsc_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level_width  <= res_w;
      level_height <= res_h;
      level_depth  <= res_d;
      level_size   <= res_size;
      row_pitch    <= res_pitch;
      total_size   <= res_total;
    end
  end

  assign sts.pipe_busy = va | vb | vc;
  assign sts.out_free  = !out_valid || !out_stall;

endmodule

// ----- design/mip_level_size_calc_core.sv -----
// Top level of the mip level size calculator: register file, sequencer, datapath.
// Depends on mlsc_pkg, mlsc_cfg_regs, mlsc_ctrl and mlsc_dp.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   input   | in_valid / in_stall  | level
//   output  | out_valid/out_stall  | level_width, level_height, level_depth,
//           |                      | level_size, row_pitch, total_size
//   config  | cfg_wr               | cfg_index, cfg_data
//
// An item goes from acceptance to its result in order: the sequencer issues all sixteen levels
// one a cycle into a three-stage multiply pipeline, drains it, scales and captures the chain sum
// and loads the output register.
// A new item is taken at the edge that loads the previous result, so items never overlap.
// Synchronous active-high reset clears the sequencer and the valid flags.
// A stalled result holds the output register; the sequencer waits before loading.
module mip_level_size_calc_core #(
  parameter int MAX_LEVELS = mlsc_pkg::MAX_LEVELS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mlsc_pkg::LEVEL_W-1:0]      level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mlsc_pkg::WIDTH_W-1:0]      level_width,
  output logic [mlsc_pkg::WIDTH_W-1:0]      level_height,
  output logic [mlsc_pkg::DEPTH_W-1:0]      level_depth,
  output logic [mlsc_pkg::SIZE_W-1:0]       level_size,
  output logic [mlsc_pkg::PITCH_W-1:0]      row_pitch,
  output logic [mlsc_pkg::TOTAL_W-1:0]      total_size,
  input  logic                              cfg_wr,
  input  logic [mlsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  mlsc_pkg::cfg_t      cfg;
  mlsc_pkg::ctrl_cmd_t cmd;
  mlsc_pkg::ctrl_sts_t sts;
  logic                busy;
  logic                take;

  assign in_stall = busy;
  assign take     = in_valid && !busy;

  mlsc_cfg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mlsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .busy     (busy),
    .cmd      (cmd),
    .sts      (sts)
  );

  mlsc_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .take         (take),
    .level        (level),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level_width  (level_width),
    .level_height (level_height),
    .level_depth  (level_depth),
    .level_size   (level_size),
    .row_pitch    (row_pitch),
    .total_size   (total_size)
  );

endmodule

// ----- design/mlsc_checker.sv -----
// Port-level checks of the mip level size calculator, bound to the top level.
// Depends on mlsc_pkg and the assertion macros in mip_level_size_calc_core_defines.svh.
`include "mip_level_size_calc_core_defines.svh"

module mlsc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [mlsc_pkg::WIDTH_W-1:0]      level_width,
  input logic [mlsc_pkg::WIDTH_W-1:0]      level_height,
  input logic [mlsc_pkg::DEPTH_W-1:0]      level_depth,
  input logic [mlsc_pkg::SIZE_W-1:0]       level_size,
  input logic [mlsc_pkg::PITCH_W-1:0]      row_pitch,
  input logic [mlsc_pkg::TOTAL_W-1:0]      total_size
);

  `MLSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled item dropped")

  `MLSC_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(level_width) && $stable(level_height) && $stable(level_depth) &&
    $stable(level_size) && $stable(row_pitch) && $stable(total_size),
    "stalled item changed")

  `MLSC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall,
    "input not held off after an item was taken")

  `MLSC_ASSERT_NOW(a_no_instant_result, $rose(out_valid), !$past(in_valid && !in_stall, 2),
    "result appeared right after the item was taken")

  `MLSC_ASSERT_NOW(a_dims_nonzero, out_valid,
    level_width != '0 && level_height != '0 && level_depth != '0,
    "zero dimension in result")

endmodule

bind mip_level_size_calc_core mlsc_checker u_mlsc_checker (.*);
